### rtl/scld_pkg.sv
// Shared types and constants for the serial command line decoder.
// Depends on nothing; every other file of the block imports it.
package scld_pkg;

    typedef struct packed {
        logic       kind;
        logic [7:0] rx_byte;
        logic [1:0] new_mode;
    } scld_cmd_t;

    typedef struct packed {
        logic [1:0]        reply;
        logic              motor_stop;
        logic [1:0]        mode;
        logic signed [7:0] speed;
        logic signed [7:0] yaw_rate;
    } scld_rsp_t;

    localparam logic KIND_BYTE = 1'b0;
    localparam logic KIND_MODE = 1'b1;

    localparam logic [1:0] REPLY_NONE    = 2'd0;
    localparam logic [1:0] REPLY_ACK     = 2'd1;
    localparam logic [1:0] REPLY_REFUSED = 2'd2;
    localparam logic [1:0] REPLY_UNKNOWN = 2'd3;

    localparam logic [1:0] MODE_WAIT   = 2'd0;
    localparam logic [1:0] MODE_MOVING = 2'd1;
    localparam logic [1:0] MODE_EMERG  = 2'd2;
    localparam logic [1:0] MODE_NONE   = 2'd3;

    localparam logic [7:0] CH_CR    = 8'd13;
    localparam logic [7:0] CH_LF    = 8'd10;
    localparam logic [7:0] CH_SP    = 8'd32;
    localparam logic [7:0] CH_TAB   = 8'd9;
    localparam logic [7:0] CH_VT    = 8'd11;
    localparam logic [7:0] CH_FF    = 8'd12;
    localparam logic [7:0] CH_PLUS  = 8'd43;
    localparam logic [7:0] CH_MINUS = 8'd45;
    localparam logic [7:0] CH_COMMA = 8'd44;
    localparam logic [7:0] CH_ZERO  = 8'd48;
    localparam logic [7:0] CH_NINE  = 8'd57;

    localparam int PREFIX_LEN = 7;

    // Prefix texts; the first character sits in the most significant byte.
    localparam logic [PREFIX_LEN-1:0][7:0] TXT_REF = "$PCREF,";
    localparam logic [PREFIX_LEN-1:0][7:0] TXT_STP = "$PCSTP,";
    localparam logic [PREFIX_LEN-1:0][7:0] TXT_STT = "$PCSTT,";

    localparam logic [9:0] ACC_MAX = 10'd1023;
    localparam logic [9:0] REF_LIMIT = 10'd100;

    typedef enum logic [7:0] {
        PH_PRE1  = 8'b0000_0001,
        PH_SIGN1 = 8'b0000_0010,
        PH_DIG1  = 8'b0000_0100,
        PH_PRE2  = 8'b0000_1000,
        PH_SIGN2 = 8'b0001_0000,
        PH_DIG2  = 8'b0010_0000,
        PH_FAIL  = 8'b0100_0000,
        PH_DONE  = 8'b1000_0000
    } scld_phase_t;

endpackage

### rtl/serial_command_line_decoder_unit.sv
// A result beat passes through the input register and then the result register.
// One input beat per cycle unless the result side stalls; single decode stage.
// The input register and the result register decouple both sides of the handshake.
// Reset (rst_n, asynchronous, active low) sets wait mode, zero references, empty line.
// Top level of the serial command line decoder; instantiates scld_core.
// Depends on scld_pkg for the beat types.
module serial_command_line_decoder_unit import scld_pkg::*; #(
    parameter int LINE_MAX = 64
) (
    input  logic      clk,
    input  logic      rst_n,
    input  logic      cmd_valid,
    output logic      cmd_ready,
    input  scld_cmd_t cmd,
    output logic      rsp_valid,
    input  logic      rsp_ready,
    output scld_rsp_t rsp
);

    logic      item_valid_reg, item_valid_next;
    scld_cmd_t item_reg;
    logic      rsp_valid_reg, rsp_valid_next;
    scld_rsp_t rsp_reg;
    logic      out_free;
    logic      advance;
    logic      res_valid;
    scld_rsp_t result;

    assign out_free  = !rsp_valid_reg || rsp_ready;
    assign advance   = item_valid_reg && out_free;
    assign cmd_ready = !item_valid_reg || out_free;

    scld_core #(
        .LINE_MAX (LINE_MAX)
    ) u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .step      (advance),
        .item      (item_reg),
        .res_valid (res_valid),
        .result    (result)
    );

    always_comb
    begin
        item_valid_next = item_valid_reg;
        if (cmd_valid && cmd_ready)
        begin
            item_valid_next = 1'b1;
        end
        else if (advance)
        begin
            item_valid_next = 1'b0;
        end

        rsp_valid_next = rsp_valid_reg;
        if (advance && res_valid)
        begin
            rsp_valid_next = 1'b1;
        end
        else if (rsp_ready)
        begin
            rsp_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_valid_reg <= 1'b0;
            rsp_valid_reg  <= 1'b0;
        end
        else
        begin
            item_valid_reg <= item_valid_next;
            rsp_valid_reg  <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd_valid && cmd_ready)
        begin
            item_reg <= cmd;
        end
        if (advance && res_valid)
        begin
            rsp_reg <= result;
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

endmodule

### rtl/scld_core.sv
// Line state and single-pass decode of one item of the command decoder.
// Depends on scld_pkg for the item types, characters and phase codes.
module scld_core import scld_pkg::*; #(
    parameter int LINE_MAX = 64
) (
    input  logic      clk,
    input  logic      rst_n,
    input  logic      step,
    input  scld_cmd_t item,
    output logic      res_valid,
    output scld_rsp_t result
);

    localparam int LW = $clog2(LINE_MAX);

    logic [1:0]        mode_reg, mode_next;
    logic [LW-1:0]     len_reg, len_next;
    logic [2:0]        match_reg, match_next;
    scld_phase_t       phase_reg, phase_next;
    logic              neg_reg, neg_next;
    logic [9:0]        acc_reg, acc_next;
    logic              first_neg_reg, first_neg_next;
    logic [9:0]        first_mag_reg, first_mag_next;
    logic signed [7:0] speed_reg, speed_next;
    logic signed [7:0] yaw_reg, yaw_next;

    logic [7:0]  c;
    logic        ws;
    logic        dig;
    logic [3:0]  d;
    logic [13:0] grown;
    logic [9:0]  acc_added;
    logic [2:0]  pos;
    logic [1:0]  reply;
    logic        stop;

    assign c = item.rx_byte;
    assign ws = (c == CH_SP) || (c == CH_TAB) || (c == CH_VT) || (c == CH_FF);
    assign dig = c inside {[CH_ZERO:CH_NINE]};
    assign d = c[3:0];
    assign grown = 14'(acc_reg) * 14'd10 + 14'(d);
    assign acc_added = (grown > 14'(ACC_MAX)) ? ACC_MAX : grown[9:0];
    assign pos = 3'(PREFIX_LEN - 1) - len_reg[2:0];

    always_comb
    begin
        mode_next      = mode_reg;
        len_next       = len_reg;
        match_next     = match_reg;
        phase_next     = phase_reg;
        neg_next       = neg_reg;
        acc_next       = acc_reg;
        first_neg_next = first_neg_reg;
        first_mag_next = first_mag_reg;
        speed_next     = speed_reg;
        yaw_next       = yaw_reg;
        res_valid      = 1'b0;
        reply          = REPLY_NONE;
        stop           = 1'b0;

        if (step)
        begin
            if (item.kind == KIND_MODE)
            begin
                if (item.new_mode != MODE_NONE)
                begin
                    mode_next = item.new_mode;
                end
                res_valid = 1'b1;
            end
            else if ((c == CH_CR) || (c == CH_LF))
            begin
                if (len_reg != '0)
                begin
                    res_valid = 1'b1;
                    if ((len_reg < LW'(PREFIX_LEN)) || (match_reg == 3'b000))
                    begin
                        reply = REPLY_UNKNOWN;
                    end
                    else if (match_reg[0])
                    begin
                        if (((phase_reg == PH_DIG2) || (phase_reg == PH_DONE)) &&
                            (first_mag_reg <= REF_LIMIT) && (acc_reg <= REF_LIMIT))
                        begin
                            speed_next = first_neg_reg ? -8'(first_mag_reg)
                                                       : 8'(first_mag_reg);
                            yaw_next   = neg_reg ? -8'(acc_reg) : 8'(acc_reg);
                        end
                    end
                    else if (mode_reg == MODE_EMERG)
                    begin
                        reply = REPLY_REFUSED;
                    end
                    else if (match_reg[1])
                    begin
                        mode_next = MODE_WAIT;
                        stop      = 1'b1;
                        reply     = REPLY_ACK;
                    end
                    else
                    begin
                        mode_next = MODE_MOVING;
                        reply     = REPLY_ACK;
                    end
                    len_next       = '0;
                    match_next     = 3'b111;
                    phase_next     = PH_PRE1;
                    neg_next       = 1'b0;
                    acc_next       = '0;
                    first_neg_next = 1'b0;
                    first_mag_next = '0;
                end
            end
            else if (len_reg < LW'(LINE_MAX - 1))
            begin
                len_next = len_reg + 1'b1;
                if (len_reg < LW'(PREFIX_LEN))
                begin
                    match_next[0] = match_reg[0] && (c == TXT_REF[pos]);
                    match_next[1] = match_reg[1] && (c == TXT_STP[pos]);
                    match_next[2] = match_reg[2] && (c == TXT_STT[pos]);
                end
                else
                begin
                    case (phase_reg)
                        PH_PRE1, PH_PRE2:
                        begin
                            if (ws)
                            begin
                                phase_next = phase_reg;
                            end
                            else if ((c == CH_PLUS) || (c == CH_MINUS))
                            begin
                                neg_next   = (c == CH_MINUS);
                                phase_next = (phase_reg == PH_PRE1) ? PH_SIGN1 : PH_SIGN2;
                            end
                            else if (dig)
                            begin
                                neg_next   = 1'b0;
                                acc_next   = 10'(d);
                                phase_next = (phase_reg == PH_PRE1) ? PH_DIG1 : PH_DIG2;
                            end
                            else
                            begin
                                phase_next = PH_FAIL;
                            end
                        end
                        PH_SIGN1, PH_SIGN2:
                        begin
                            if (dig)
                            begin
                                acc_next   = 10'(d);
                                phase_next = (phase_reg == PH_SIGN1) ? PH_DIG1 : PH_DIG2;
                            end
                            else
                            begin
                                phase_next = PH_FAIL;
                            end
                        end
                        PH_DIG1:
                        begin
                            if (dig)
                            begin
                                acc_next = acc_added;
                            end
                            else if (c == CH_COMMA)
                            begin
                                first_neg_next = neg_reg;
                                first_mag_next = acc_reg;
                                acc_next       = '0;
                                neg_next       = 1'b0;
                                phase_next     = PH_PRE2;
                            end
                            else
                            begin
                                phase_next = PH_FAIL;
                            end
                        end
                        PH_DIG2:
                        begin
                            if (dig)
                            begin
                                acc_next = acc_added;
                            end
                            else
                            begin
                                phase_next = PH_DONE;
                            end
                        end
                        default:
                        begin
                            phase_next = phase_reg;
                        end
                    endcase
                end
            end
        end
    end

    always_comb
    begin
        result.reply      = reply;
        result.motor_stop = stop;
        result.mode       = mode_next;
        result.speed      = speed_next;
        result.yaw_rate   = yaw_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg      <= MODE_WAIT;
            len_reg       <= '0;
            match_reg     <= 3'b111;
            phase_reg     <= PH_PRE1;
            neg_reg       <= 1'b0;
            acc_reg       <= '0;
            first_neg_reg <= 1'b0;
            first_mag_reg <= '0;
            speed_reg     <= '0;
            yaw_reg       <= '0;
        end
        else
        begin
            mode_reg      <= mode_next;
            len_reg       <= len_next;
            match_reg     <= match_next;
            phase_reg     <= phase_next;
            neg_reg       <= neg_next;
            acc_reg       <= acc_next;
            first_neg_reg <= first_neg_next;
            first_mag_reg <= first_mag_next;
            speed_reg     <= speed_next;
            yaw_reg       <= yaw_next;
        end
    end

endmodule

### rtl/scld_checker.sv
// Port-level checks of the serial command line decoder, bound to its top level.
// Depends on scld_pkg for the beat types and reply and mode codes.
module scld_checker import scld_pkg::*; (
    input logic      clk,
    input logic      rst_n,
    input logic      rsp_valid,
    input logic      rsp_ready,
    input scld_rsp_t rsp
);

    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp)))
        else $error("Result beat dropped or changed while stalled.");

    a_stop_ack: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && rsp.motor_stop) |-> (rsp.reply == REPLY_ACK && rsp.mode == MODE_WAIT))
        else $error("Motor stop without an accepted stop command.");

    a_refuse_emerg: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && rsp.reply == REPLY_REFUSED) |-> (rsp.mode == MODE_EMERG))
        else $error("Refusal outside emergency mode.");

    a_ref_range: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> (rsp.speed >= -8'sd100 && rsp.speed <= 8'sd100 &&
                       rsp.yaw_rate >= -8'sd100 && rsp.yaw_rate <= 8'sd100))
        else $error("Reference outside the allowed range.");

    a_mode_code: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> (rsp.mode != MODE_NONE))
        else $error("Reported mode has no meaning.");

endmodule

bind serial_command_line_decoder_unit scld_checker u_scld_checker (.*);
